// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl modules
// each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/dteq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dteq_pkg
// Types and constants shared by the due-time event queue modules.
// ----------------------------------------------------------------------------
package dteq_pkg;

    // request action codes
    localparam logic ACTION_SCHEDULE = 1'b0;
    localparam logic ACTION_TICK     = 1'b1;

    // response kind codes
    localparam logic RESULT_ACK     = 1'b0;
    localparam logic RESULT_RELEASE = 1'b1;

    // most events released by one tick
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic        action;
        logic [15:0] object_id;
        logic [3:0]  event_kind;
        logic [31:0] wake_time;
        logic [31:0] current_time;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic        dropped;
        logic [15:0] due_object_id;
        logic [3:0]  due_event_kind;
        logic        last_due;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic insert;
        logic pop;
        logic emit_ack;
        logic emit_release;
        logic last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic front_due;
        logic next_due;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/dteq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dteq_ctrl
// Sequencer: accepts one request, runs the insert or the release loop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dteq_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_action,
    output logic                 req_stall,
    input  wire dteq_pkg::sts_t  sts,
    output dteq_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_TICK
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [dteq_pkg::CNT_W-1:0] cnt_reg;
    logic [dteq_pkg::CNT_W-1:0] cnt_next;
    logic                       cnt_at_max;

    // release count reaches the per-tick cap after this transaction
    assign cnt_at_max = (cnt_reg == dteq_pkg::CNT_W'(dteq_pkg::MAX_RESULTS - 1));

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cnt_next     = '0;
                    state_next   = (req_action == dteq_pkg::ACTION_TICK) ? ST_TICK : ST_SCHED;
                end
            end
            ST_SCHED:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    cmd.insert   = !sts.full;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (sts.out_free)
                begin
                    if (sts.front_due)
                    begin
                        cmd.emit_release = 1'b1;
                        cmd.pop          = 1'b1;
                        cmd.last         = !(sts.next_due && !cnt_at_max);
                        cnt_next         = cnt_reg + dteq_pkg::CNT_W'(1);
                        if (cmd.last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and release counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    // checks
    `ASSERT_IMPL(a_emit_needs_slot, cmd.emit_ack || cmd.emit_release, sts.out_free)
    `ASSERT_IMPL(a_release_only_due, cmd.emit_release, sts.front_due)
    `ASSERT_NEXT(a_last_returns_idle, cmd.last, state_reg == ST_IDLE)

endmodule
`default_nettype wire

// ----- rtl/core/dteq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dteq_datapath
// Sorted register file of events, request holding register and response
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dteq_datapath
#(
    parameter int unsigned DEPTH = 32
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dteq_pkg::req_t  req,
    input  wire dteq_pkg::cmd_t  cmd,
    output dteq_pkg::sts_t       sts,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output dteq_pkg::rsp_t       rsp
);

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    logic [31:0]       times_reg [DEPTH];
    logic [31:0]       times_next [DEPTH];
    logic [15:0]       objs_reg [DEPTH];
    logic [15:0]       objs_next [DEPTH];
    logic [3:0]        kinds_reg [DEPTH];
    logic [3:0]        kinds_next [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    dteq_pkg::req_t    req_reg;
    dteq_pkg::rsp_t    rsp_reg;
    dteq_pkg::rsp_t    rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [DEPTH-1:0]  le;

    // entries that stay ahead of the new event (sorted, so a prefix)
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            le[i] = (FILL_W'(i) < fill_reg) && (times_reg[i] <= req_reg.wake_time);
        end
    end

    // insert shifts the tail up, pop shifts everything down
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            times_next[i] = times_reg[i];
            objs_next[i]  = objs_reg[i];
            kinds_next[i] = kinds_reg[i];
        end
        fill_next = fill_reg;
        if (cmd.insert)
        begin
            if (!le[0])
            begin
                times_next[0] = req_reg.wake_time;
                objs_next[0]  = req_reg.object_id;
                kinds_next[0] = req_reg.event_kind;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!le[i])
                begin
                    if (le[i-1])
                    begin
                        times_next[i] = req_reg.wake_time;
                        objs_next[i]  = req_reg.object_id;
                        kinds_next[i] = req_reg.event_kind;
                    end
                    else
                    begin
                        times_next[i] = times_reg[i-1];
                        objs_next[i]  = objs_reg[i-1];
                        kinds_next[i] = kinds_reg[i-1];
                    end
                end
            end
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                times_next[i] = times_reg[i+1];
                objs_next[i]  = objs_reg[i+1];
                kinds_next[i] = kinds_reg[i+1];
            end
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.full      = (fill_reg == FILL_W'(DEPTH));
        sts.front_due = (fill_reg != '0) && (times_reg[0] <= req_reg.current_time);
        sts.next_due  = (fill_reg > FILL_W'(1)) && (times_reg[1] <= req_reg.current_time);
        sts.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    // response register load and drain
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit_ack)
        begin
            rsp_next                = '0;
            rsp_next.result_kind    = dteq_pkg::RESULT_ACK;
            rsp_next.dropped        = sts.full;
            rsp_valid_next          = 1'b1;
        end
        else if (cmd.emit_release)
        begin
            rsp_next                = '0;
            rsp_next.result_kind    = dteq_pkg::RESULT_RELEASE;
            rsp_next.due_object_id  = objs_reg[0];
            rsp_next.due_event_kind = kinds_reg[0];
            rsp_next.last_due       = cmd.last;
            rsp_valid_next          = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            times_reg[i] <= times_next[i];
            objs_reg[i]  <= objs_next[i];
            kinds_reg[i] <= kinds_next[i];
        end
        rsp_reg <= rsp_next;
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `ASSERT_IMPL(a_fill_range, 1'b1, fill_reg <= FILL_W'(DEPTH))
    `ASSERT_IMPL(a_no_pop_empty, cmd.pop, fill_reg != '0)
    `ASSERT_NEXT(a_insert_grows, cmd.insert, fill_reg == $past(fill_reg) + FILL_W'(1))

endmodule
`default_nettype wire

// ----- rtl/core/due_time_event_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// the first response is registered from the SCHED or TICK state after the request is accepted
// a schedule is accepted, then inserted into the sorted entries in one parallel step unless full
// a tick releases due events earliest first and gives no response when nothing is due
// back-pressure on the response port holds the sequencer until the response register is free
// reset: rst_n asynchronous active low, empties the queue; no clearing pass is needed
// ----------------------------------------------------------------------------
// due_time_event_queue
// Bounded queue of timed events ordered by wakeup time; ticks release due
// events earliest first.
// ----------------------------------------------------------------------------
module due_time_event_queue
#(
    parameter int unsigned QUEUE_DEPTH = 32
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire dteq_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output dteq_pkg::rsp_t       rsp
);

    dteq_pkg::cmd_t cmd;
    dteq_pkg::sts_t sts;

    // sequencer
    dteq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_stall  (req_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // entry storage and response register
    dteq_datapath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// due_time_event_queue testbench
// Schedules events and issues ticks on the request port, keeps its own sorted
// copy of the queue to predict acknowledgments and released events, and
// compares every response field with the oldest prediction. Sender gaps and
// response stalls change from phase to phase.
// ----------------------------------------------------------------------------

// one stored event of the predicted queue
typedef struct packed {
    logic [31:0] wake;
    logic [15:0] obj;
    logic [3:0]  kind;
} held_event_t;

// sorted event store and list of awaited responses
class wakeup_order_checker;
    held_event_t            pending_events[$];
    dteq_pkg::rsp_t         awaited_rsp[$];
    int unsigned            depth;
    int unsigned            failures;

    function new(int unsigned queue_depth);
        depth    = queue_depth;
        failures = 0;
    endfunction

    // predict the responses caused by one accepted request
    function void note_request(dteq_pkg::req_t item);
        dteq_pkg::rsp_t res;
        held_event_t    ev;
        int unsigned    pos;
        int unsigned    released;
        res = '0;
        if (item.action == dteq_pkg::ACTION_SCHEDULE)
        begin
            res.result_kind = dteq_pkg::RESULT_ACK;
            if (pending_events.size() >= depth)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                // new event goes after every stored event not later than it
                ev.wake = item.wake_time;
                ev.obj  = item.object_id;
                ev.kind = item.event_kind;
                pos = 0;
                while (pos < pending_events.size() && pending_events[pos].wake <= item.wake_time)
                    pos++;
                pending_events.insert(pos, ev);
            end
            awaited_rsp.insert(awaited_rsp.size(), res);
        end
        else
        begin
            // release due events from the front, earliest first
            released = 0;
            while (pending_events.size() > 0 && released < dteq_pkg::MAX_RESULTS
                   && pending_events[0].wake <= item.current_time)
            begin
                res                = '0;
                res.result_kind    = dteq_pkg::RESULT_RELEASE;
                res.due_object_id  = pending_events[0].obj;
                res.due_event_kind = pending_events[0].kind;
                res.last_due       = (pending_events.size() == 1)
                                     || (released + 1 == dteq_pkg::MAX_RESULTS)
                                     || (pending_events[1].wake > item.current_time);
                awaited_rsp.insert(awaited_rsp.size(), res);
                void'(pending_events.pop_front());
                released++;
            end
        end
    endfunction

    // compare one accepted response with the oldest prediction
    function void check_response(dteq_pkg::rsp_t got);
        dteq_pkg::rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            $error("response with none awaited: kind %0d object %0h", got.result_kind,
                   got.due_object_id);
            failures++;
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.result_kind !== want.result_kind)
        begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            failures++;
        end
        if (got.dropped !== want.dropped)
        begin
            $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
            failures++;
        end
        if (got.due_object_id !== want.due_object_id)
        begin
            $error("due_object_id: expected %0h, got %0h", want.due_object_id,
                   got.due_object_id);
            failures++;
        end
        if (got.due_event_kind !== want.due_event_kind)
        begin
            $error("due_event_kind: expected %0h, got %0h", want.due_event_kind,
                   got.due_event_kind);
            failures++;
        end
        if (got.last_due !== want.last_due)
        begin
            $error("last_due: expected %0d, got %0d", want.last_due, got.last_due);
            failures++;
        end
    endfunction

    function int unsigned outstanding();
        return awaited_rsp.size();
    endfunction
endclass

module testbench;

    localparam int unsigned QUEUE_DEPTH    = 32;
    localparam int unsigned PHASE_REQUESTS = 55;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned STUCK_LIMIT    = 5000;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned REQ_W          = $bits(dteq_pkg::req_t);

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    dteq_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    dteq_pkg::rsp_t rsp;

    wakeup_order_checker sb;
    int unsigned         send_idle_pct  = 0;
    int unsigned         stall_pct      = 0;
    bit                  rsp_hold       = 1'b0;
    bit                  start_holdoff  = 1'b0;
    int unsigned         requests_sent  = 0;
    int unsigned         stuck_cycles   = 0;

    due_time_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // response stall, driven at the falling edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_stall <= rsp_hold || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // long response hold-off so the queue backs up into the request port
    initial
    begin
        wait (start_holdoff);
        rsp_hold = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // response monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // offer one request and hold it until accepted
    task automatic offer_request(input dteq_pkg::req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(item);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic schedule_event(input logic [15:0] obj, input logic [3:0] kind,
                                  input logic [31:0] wake);
        dteq_pkg::req_t item;
        item.action       = dteq_pkg::ACTION_SCHEDULE;
        item.object_id    = obj;
        item.event_kind   = kind;
        item.wake_time    = wake;
        item.current_time = $urandom;
        offer_request(item);
    endtask

    task automatic tick_at(input logic [31:0] now);
        dteq_pkg::req_t item;
        item.action       = dteq_pkg::ACTION_TICK;
        item.object_id    = 16'($urandom);
        item.event_kind   = 4'($urandom);
        item.wake_time    = $urandom;
        item.current_time = now;
        offer_request(item);
    endtask

    // burst of 30 to 36 schedules, up to past the queue depth, then one tick over the window
    task automatic fill_window();
        logic [31:0] base;
        int unsigned count;
        base  = $urandom_range(0, 32'hFFFF_FE00);
        count = $urandom_range(30, 36);
        repeat (count)
            schedule_event(16'($urandom), 4'($urandom), base + $urandom_range(0, 255));
        tick_at(base + 255);
    endtask

    task automatic wait_for_responses();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [31:0]    base;
        logic [31:0]    now;
        int unsigned    span;
        int unsigned    count;
        dteq_pkg::req_t noise;
        sb = new(QUEUE_DEPTH);

        // reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: nothing due on an empty queue, field extremes, ties
        tick_at(32'hFFFF_FFFF);
        schedule_event(16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        schedule_event(16'h0000, 4'h0, 32'h0000_0000);
        schedule_event(16'h1234, 4'h5, 32'd100);
        schedule_event(16'h00AA, 4'h3, 32'd100);
        schedule_event(16'h0055, 4'hC, 32'd100);
        schedule_event(16'h0007, 4'h9, 32'd50);
        tick_at(32'd0);
        tick_at(32'd99);
        tick_at(32'd49);
        tick_at(32'd100);
        tick_at(32'hFFFF_FFFE);
        tick_at(32'hFFFF_FFFF);
        wait_for_responses();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 74;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 74;
                end
                default:
                begin
                    send_idle_pct = 23;
                    stall_pct     = 23;
                end
            endcase
            requests_sent = 0;

            // first phase opens with the response port held off
            if (phase == 0)
            begin
                start_holdoff = 1'b1;
                fill_window();
            end

            while (requests_sent < PHASE_REQUESTS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        // schedules in a time window, then ticks walking through it
                        base  = $urandom_range(0, 32'hFFFF_0000);
                        span  = $urandom_range(1, 2000);
                        count = $urandom_range(1, 8);
                        repeat (count)
                            schedule_event(16'($urandom), 4'($urandom),
                                           base + $urandom_range(0, span));
                        now   = base;
                        count = $urandom_range(1, 3);
                        repeat (count)
                        begin
                            now = now + $urandom_range(0, span);
                            tick_at(now);
                        end
                    end
                    4, 5:
                        fill_window();
                    6, 7:
                    begin
                        // unstructured requests
                        count = $urandom_range(1, 4);
                        repeat (count)
                        begin
                            noise = REQ_W'({$urandom, $urandom, $urandom});
                            offer_request(noise);
                        end
                    end
                    8:
                        tick_at($urandom);
                    default:
                        tick_at(32'hFFFF_FFFF);
                endcase
            end

            // sender pauses until every response has come back
            req_valid <= 1'b0;
            wait_for_responses();
            @(negedge clk);
        end

        // let the block settle, then report
        wait_for_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
